### src/aging_tag_buffer_with_match_consume_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the aging tag buffer
// Implication forms, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef AGING_TAG_BUFFER_WITH_MATCH_CONSUME_MACROS_SVH
`define AGING_TAG_BUFFER_WITH_MATCH_CONSUME_MACROS_SVH

// same-cycle implication
`define ATB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ATB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/atb_pkg.sv
// ---------------------------------------------------------------------------
// atb_pkg
// Types and constants shared by the aging tag buffer modules.
// ---------------------------------------------------------------------------
package atb_pkg;

   localparam int ATB_DEPTH_DEFAULT = 8;

   localparam int TAG_W       = 5;
   localparam int TIME_W      = 32;
   localparam int MASK_W      = 32;
   localparam int ACT_W       = 3;
   localparam int LIMIT_W     = 4;
   localparam int WIN_W       = 16;
   localparam int OUT_COUNT_W = 4;

   localparam int REQ_FIELDS_W = TIME_W + TAG_W + MASK_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam logic [TIME_W-1:0]  HOLD_RESET  = TIME_W'(1000);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH    = 3'd0,
      ACT_OPEN    = 3'd1,
      ACT_CLOSE   = 3'd2,
      ACT_CONSUME = 3'd3,
      ACT_CLEAR   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      REG_HOLD  = 2'd0,
      REG_LIMIT = 2'd1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [TIME_W-1:0] now;
      logic [TAG_W-1:0]  tag;
      logic [MASK_W-1:0] mask;
   } req_type;

   typedef struct packed {
      logic [OUT_COUNT_W-1:0] count;
      logic                   window_open;
      logic [TAG_W-1:0]       tag;
      logic                   consumed;
   } result_type;

   localparam int RSP_FIELDS_W = $bits(result_type);
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

### src/aging_tag_buffer_with_match_consume.sv
// ---------------------------------------------------------------------------
// Aging tag buffer with match consume
// Age-ordered buffer of tagged events with expiry, limit and window gating.
// ---------------------------------------------------------------------------
// Input words arrive on req_ (tuser = action, tdata = time, tag, mask) and
// each one yields exactly one result word on rsp_ (consumed flag, tag,
// window state, entry count). Registers hold_ticks and entry_limit are set
// through the csr_ port; the user must write them only while the block is
// idle, which the block does not enforce. Open, close, clear, reserved codes,
// ignored pushes and ignored consumes go from accept straight to the done
// state. A push or other consume walks the entries one per cycle through the
// single read port of the entry memory, first past the one age compare for
// expiry and match search, then again for compaction after a removal.
// The block takes one word at a time; req_tready is high only when idle.
// The result sits in an output register; while rsp_tready is low the result
// is held and the sequencer waits before returning to idle.
// Reset empties the buffer, closes the window and sets hold_ticks to 1000
// and entry_limit to 8; the entry memory itself is not cleared.
// ---------------------------------------------------------------------------
`include "aging_tag_buffer_with_match_consume_macros.svh"

module aging_tag_buffer_with_match_consume import atb_pkg::*; #(
   parameter int DEPTH = ATB_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_ticks[31:0], event_tag[36:32], allowed_mask[68:37], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[2:0]
   input  logic [ACT_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // consumed[0], consumed_tag[5:1], window_open[6], entry_count[10:7], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [TIME_W-1:0]  hold_ff, hold_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;
   logic               csr_wr;
   reg_index_type      csr_idx;
   req_type            req;
   logic               res_valid, res_take;
   result_type         res;
   logic               rsp_hit, rsp_miss;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'({1'b0, csr_paddr[2]});

   always_comb begin
      hold_in  = hold_ff;
      limit_in = limit_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_HOLD:  hold_in  = csr_pwdata[TIME_W-1:0];
            REG_LIMIT: limit_in = csr_pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
      case (csr_idx)
         REG_HOLD:  csr_prdata = hold_ff;
         REG_LIMIT: csr_prdata = 32'(limit_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_comb begin
      req.action = req_tuser;
      req.now    = req_tdata[TIME_W-1:0];
      req.tag    = req_tdata[TIME_W+TAG_W-1:TIME_W];
      req.mask   = req_tdata[REQ_FIELDS_W-1:TIME_W+TAG_W];
   end

   atb_seq #(.DEPTH(DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .hold_ticks  (hold_ff),
      .entry_limit (limit_ff),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= HOLD_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   assign rsp_hit  = rsp_valid_ff && rsp_data_ff.consumed;
   assign rsp_miss = rsp_valid_ff && !rsp_data_ff.consumed;

   `ATB_ASSERT_IMP(a_tag_zero_on_miss, rsp_miss, rsp_data_ff.tag == '0, "tag set on a miss")
   `ATB_ASSERT_IMP(a_hit_tag_nonzero, rsp_hit, rsp_data_ff.tag != '0, "hit returned tag zero")
   `ATB_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "taken while busy")

endmodule

### src/atb_store.sv
// ---------------------------------------------------------------------------
// atb_store
// Entry memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module atb_store import atb_pkg::*; #(
   parameter int DEPTH = ATB_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_entry,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_entry
);

   // one spare slot so an append never collides with the oldest entry
   localparam int ENTRIES = DEPTH + 1;

   entry_type mem [ENTRIES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

### src/atb_seq.sv
// ---------------------------------------------------------------------------
// atb_seq
// Sequencer: walks the entry memory for trim, match search and compaction,
// with one age compare for trim; holds count, base offset and window depth.
// ---------------------------------------------------------------------------
module atb_seq import atb_pkg::*; #(
   parameter int DEPTH = ATB_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req,
   input  logic [TIME_W-1:0]  hold_ticks,
   input  logic [LIMIT_W-1:0] entry_limit,
   output logic               res_valid,
   input  logic               res_take,
   output result_type         res
);

   localparam int AW = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  op_ff, op_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [AW-1:0]     count_ff, count_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [TAG_W-1:0]  hit_tag_ff, hit_tag_in;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   entry_type         rd_entry, wr_entry;
   logic [AW:0]       addr_sum;
   logic [TIME_W-1:0] age;
   logic              keep;
   logic [AW:0]       total, lim_eff, kept;
   logic [MASK_W-1:0] req_mask;

   atb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      now_in      = now_ff;
      tag_in      = tag_ff;
      mask_in     = mask_ff;
      count_in    = count_ff;
      base_in     = base_ff;
      window_in   = window_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_valid_in = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_tag_in  = hit_tag_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      addr_sum    = {1'b0, base_ff} + {1'b0, rd_ptr_ff};
      rd_addr     = addr_sum[AW-1:0];
      wr_addr     = wr_ptr_ff;
      wr_entry    = rd_entry;
      age         = now_ff - rd_entry.stamp;
      keep        = (age <= hold_ticks) || (state_ff == ST_SHIFT);
      req_mask    = req.mask & ~MASK_W'(1);
      total       = {1'b0, count_ff} + (AW + 1)'(1);
      if (32'(entry_limit) > 32'(DEPTH)) begin
         lim_eff = (AW + 1)'(DEPTH);
      end else begin
         lim_eff = (AW + 1)'(entry_limit);
      end
      kept = (total > lim_eff) ? lim_eff : total;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req.action;
               now_in    = req.now;
               tag_in    = req.tag;
               mask_in   = req_mask;
               hit_in    = 1'b0;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               state_in  = ST_DONE;
               case (req.action)
                  ACT_PUSH: begin
                     if (req.tag != '0) begin
                        state_in = ST_TRIM;
                     end
                  end
                  ACT_OPEN: begin
                     if (window_ff != '1) begin
                        window_in = window_ff + WIN_W'(1);
                     end
                  end
                  ACT_CLOSE: begin
                     if (window_ff != '0) begin
                        window_in = window_ff - WIN_W'(1);
                     end
                  end
                  ACT_CONSUME: begin
                     if (window_ff != '0 && req_mask != '0) begin
                        state_in = ST_TRIM;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     base_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TRIM, ST_SHIFT: begin
            if (rd_ptr_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_ptr_in   = rd_ptr_ff + AW'(1);
            end
            if (rd_valid_ff && keep) begin
               wr_en     = 1'b1;
               wr_ptr_in = wr_ptr_ff + AW'(1);
               if (state_ff == ST_TRIM && op_ff == ACT_CONSUME && mask_ff[rd_entry.tag]) begin
                  hit_in     = 1'b1;
                  hit_idx_in = wr_ptr_ff;
                  hit_tag_in = rd_entry.tag;
               end
            end
            if (rd_ptr_ff >= count_ff && !rd_valid_ff) begin
               if (state_ff == ST_TRIM) begin
                  count_in = wr_ptr_ff;
                  base_in  = '0;
                  if (op_ff == ACT_PUSH) begin
                     state_in = ST_APPEND;
                  end else if (hit_ff) begin
                     rd_ptr_in = hit_idx_ff + AW'(1);
                     wr_ptr_in = hit_idx_ff;
                     state_in  = ST_SHIFT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  count_in = count_ff - AW'(1);
                  state_in = ST_DONE;
               end
            end
         end
         ST_APPEND: begin
            wr_en          = 1'b1;
            wr_addr        = count_ff;
            wr_entry.tag   = tag_ff;
            wr_entry.stamp = now_ff;
            count_in       = kept[AW-1:0];
            if (kept == '0) begin
               base_in = '0;
            end else begin
               base_in = AW'(total - kept);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.consumed    = hit_ff;
      res.tag         = hit_ff ? hit_tag_ff : '0;
      res.window_open = (window_ff != '0);
      res.count       = OUT_COUNT_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         op_ff       <= ACT_PUSH;
         count_ff    <= '0;
         base_ff     <= '0;
         window_ff   <= '0;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         op_ff       <= op_in;
         count_ff    <= count_in;
         base_ff     <= base_in;
         window_ff   <= window_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_valid_ff <= rd_valid_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      tag_ff     <= tag_in;
      mask_ff    <= mask_in;
      hit_idx_ff <= hit_idx_in;
      hit_tag_ff <= hit_tag_in;
   end

endmodule

### sim/tb_aging_tag_buffer_with_match_consume.sv
// ---------------------------------------------------------------------------
// Aging tag buffer testbench
// Drives event words (push, open, close, consume, clear and unused codes)
// into the buffer and checks every status word against an in-bench model of
// the aged tag list, window counter and register settings, or against fixed
// values for some directed rows. A directed table runs first, then register
// phases of weighted random traffic with random back-pressure in all but
// the last; the run ends with bursts of window opens, closes and a consume.
// ---------------------------------------------------------------------------
module tb_aging_tag_buffer_with_match_consume;
   timeunit 1ns;
   timeprecision 1ps;
   import atb_pkg::*;

   localparam int BUF_DEPTH      = ATB_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES  = 2 * BUF_DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 100;
   localparam int WIN_TOP        = 65535;
   localparam int TAIL_WORDS     = 8;

   localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

   localparam logic [2:0] ADDR_HOLD  = 3'(4 * int'(REG_HOLD));
   localparam logic [2:0] ADDR_LIMIT = 3'(4 * int'(REG_LIMIT));

   typedef struct {
      logic [ACT_W-1:0]       act;
      logic [TIME_W-1:0]      now;
      logic [TAG_W-1:0]       tag;
      logic [MASK_W-1:0]      mask;
      bit                     fixed;
      logic                   consumed;
      logic [TAG_W-1:0]       taken;
      logic                   open;
      logic [OUT_COUNT_W-1:0] count;
   } stim_row;

   typedef struct {
      logic [TIME_W-1:0]  hold;
      logic [LIMIT_W-1:0] limit;
      int                 idle;
      int unsigned        step_max;
      int                 items;
   } phase_cfg;

   localparam int DIR_ROWS = 26;
   stim_row dir_rows [DIR_ROWS] = '{
      '{ACT_CONSUME,  32'd0,          5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_CLOSE,    32'd0,          5'd0,  32'h0,         1'b1, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_RSVD_HI,  32'hFFFF_FFFF,  5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd0,          5'd0,  32'h0,         1'b1, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_OPEN,     32'd0,          5'd0,  32'h0,         1'b1, 1'b0, 5'd0, 1'b1, 4'd0},
      '{ACT_PUSH,     32'd0,          5'd31, 32'h0,         1'b1, 1'b0, 5'd0, 1'b1, 4'd1},
      '{ACT_PUSH,     32'hFFFF_FFF0,  5'd1,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd5,          5'd2,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_CONSUME,  32'd8,          5'd0,  32'h1,         1'b1, 1'b0, 5'd0, 1'b1, 4'd2},
      '{ACT_CONSUME,  32'd8,          5'd0,  32'h0,         1'b1, 1'b0, 5'd0, 1'b1, 4'd2},
      '{ACT_CONSUME,  32'd10,         5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd20,         5'd3,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd20,         5'd4,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd20,         5'd5,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd21,         5'd6,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd21,         5'd7,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd22,         5'd8,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd22,         5'd9,  32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd23,         5'd10, 32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_CONSUME,  32'd30,         5'd0,  32'h0000_0020, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_CONSUME,  32'd30,         5'd0,  32'h8000_0000, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_RSVD_LO,  32'd31,         5'd7,  32'h0000_0080, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_CONSUME,  32'd2000,       5'd0,  32'hFFFF_FFFE, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_PUSH,     32'd2000,       5'd17, 32'h0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0},
      '{ACT_CLEAR,    32'd2000,       5'd0,  32'h0,         1'b1, 1'b0, 5'd0, 1'b1, 4'd0},
      '{ACT_CLOSE,    32'd2000,       5'd0,  32'h0,         1'b1, 1'b0, 5'd0, 1'b0, 4'd0}
   };

   localparam int PHASES = 7;
   phase_cfg phases [PHASES] = '{
      '{32'd1000,      4'd8,  20, 300,       270},
      '{32'd0,         4'd1,  30, 2,         270},
      '{32'hFFFF_FFFF, 4'd15, 10, 32'h10_0000, 270},
      '{32'd250,       4'd3,  25, 60,        270},
      '{32'd400,       4'd0,  15, 100,       270},
      '{32'd600,       4'd8,  30, 150,       270},
      '{32'd90,        4'd5,  0,  20,        270}
   };

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_tvalid   = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata    = '0;
   logic [ACT_W-1:0]       req_tuser    = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready   = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel     = 1'b0;
   logic                   csr_penable  = 1'b0;
   logic                   csr_pwrite   = 1'b0;
   logic [2:0]             csr_paddr    = '0;
   logic [31:0]            csr_pwdata   = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   aging_tag_buffer_with_match_consume DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // model of the buffer, oldest entry first
   entry_type          aged_list[$];
   logic [TIME_W-1:0]  hold_cfg  = HOLD_RESET;
   logic [LIMIT_W-1:0] limit_cfg = LIMIT_RESET;
   logic [WIN_W-1:0]   win_depth = '0;

   result_type         status_due[$];
   int                 fail_count = 0;
   int                 idle_pct   = 0;
   int                 rsp_stall  = 0;
   int                 quiet_cycles = 0;
   logic [TIME_W-1:0]  cur_tick   = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
   endfunction

   function automatic void drop_expired(logic [TIME_W-1:0] now);
      entry_type         kept[$];
      logic [TIME_W-1:0] age;
      foreach (aged_list[i]) begin
         age = now - aged_list[i].stamp;
         if (age <= hold_cfg)
            kept.push_back(aged_list[i]);
      end
      aged_list = kept;
   endfunction

   function automatic result_type apply_tag_event(logic [ACT_W-1:0] act, logic [TIME_W-1:0] now,
                                                 logic [TAG_W-1:0] tag, logic [MASK_W-1:0] mask);
      result_type        res;
      entry_type         fresh;
      logic [MASK_W-1:0] eligible;
      int                lim;
      int                hit;
      res = '0;
      case (act)
         ACT_PUSH: begin
            if (tag != '0) begin
               drop_expired(now);
               if (aged_list.size() >= BUF_DEPTH)
                  void'(aged_list.pop_front());
               fresh.tag   = tag;
               fresh.stamp = now;
               aged_list.push_back(fresh);
               lim = (limit_cfg > BUF_DEPTH) ? BUF_DEPTH : int'(limit_cfg);
               while (aged_list.size() > lim)
                  void'(aged_list.pop_front());
            end
         end
         ACT_OPEN: begin
            if (win_depth != WIN_W'(WIN_TOP))
               win_depth++;
         end
         ACT_CLOSE: begin
            if (win_depth != '0)
               win_depth--;
         end
         ACT_CONSUME: begin
            eligible = mask & ~MASK_W'(1);
            if (win_depth != '0 && eligible != '0) begin
               drop_expired(now);
               hit = -1;
               for (int i = aged_list.size() - 1; i >= 0 && hit < 0; i--)
                  if (eligible[aged_list[i].tag])
                     hit = i;
               if (hit >= 0) begin
                  res.consumed = 1'b1;
                  res.tag      = aged_list[hit].tag;
                  aged_list.delete(hit);
               end
            end
         end
         ACT_CLEAR: begin
            aged_list.delete();
         end
         default: ;
      endcase
      res.window_open = (win_depth != '0);
      res.count       = OUT_COUNT_W'(aged_list.size());
      return res;
   endfunction

   task automatic send_word(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] now,
                            input logic [TAG_W-1:0] tag, input logic [MASK_W-1:0] mask,
                            input bit fixed, input result_type fixed_res);
      result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_TDATA_W'({mask, tag, now});
      do @(posedge clock); while (!req_tready);
      predicted = apply_tag_event(act, now, tag, mask);
      status_due.push_back(fixed ? fixed_res : predicted);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (status_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input string field, input logic [2:0] addr,
                                 input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      flag_field(field, want, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_word(input int unsigned step_max);
      logic [ACT_W-1:0]  act;
      logic [TAG_W-1:0]  tag;
      logic [MASK_W-1:0] mask;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         cur_tick = $urandom;
      else if (pick < 7)
         cur_tick = cur_tick + $urandom;
      else
         cur_tick = cur_tick + $urandom_range(0, step_max);

      pick = $urandom_range(0, 99);
      if (pick < 45)
         act = ACT_PUSH;
      else if (pick < 75)
         act = ACT_CONSUME;
      else if (pick < 87)
         act = ACT_OPEN;
      else if (pick < 93)
         act = ACT_CLOSE;
      else if (pick < 96)
         act = ACT_CLEAR;
      else
         act = ACT_W'($urandom_range(int'(ACT_RSVD_LO), int'(ACT_RSVD_HI)));

      pick = $urandom_range(0, 99);
      if (pick < 8)
         tag = '0;
      else if (pick < 75)
         tag = TAG_W'($urandom_range(1, 6));
      else
         tag = TAG_W'($urandom_range(1, 31));

      pick = $urandom_range(0, 99);
      if (pick < 35)
         mask = $urandom & 32'h0000_007E;
      else if (pick < 55)
         mask = MASK_W'(1) << $urandom_range(1, 6);
      else if (pick < 70)
         mask = $urandom;
      else if (pick < 80)
         mask = '1;
      else if (pick < 85)
         mask = '0;
      else if (pick < 90)
         mask = MASK_W'(1);
      else
         mask = MASK_W'(1) << $urandom_range(1, 31);

      send_word(act, cur_tick, tag, mask, 1'b0, '0);
   endtask

   // status word checker
   always @(posedge clock) begin : status_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (status_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $error("status word 0x%0h with no expectation pending", rsp_tdata);
         end else begin
            want = status_due.pop_front();
            flag_field("consumed", 32'(want.consumed), 32'(got.consumed));
            flag_field("consumed_tag", 32'(want.tag), 32'(got.tag));
            flag_field("window_open", 32'(want.window_open), 32'(got.window_open));
            flag_field("entry_count", 32'(want.count), 32'(got.count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_stall == 0 && idle_pct > 0 && $urandom_range(0, 299) < idle_pct)
            rsp_stall = $urandom_range(1, 6);
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      result_type want;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_read_check("hold_ticks", ADDR_HOLD, 32'(HOLD_RESET));
      csr_read_check("entry_limit", ADDR_LIMIT, 32'(LIMIT_RESET));

      idle_pct = 20;
      foreach (dir_rows[r]) begin
         want.consumed    = dir_rows[r].consumed;
         want.tag         = dir_rows[r].taken;
         want.window_open = dir_rows[r].open;
         want.count       = dir_rows[r].count;
         send_word(dir_rows[r].act, dir_rows[r].now, dir_rows[r].tag, dir_rows[r].mask,
                   dir_rows[r].fixed, want);
      end
      cur_tick = 32'd2000;

      foreach (phases[p]) begin
         drain_results();
         csr_write(ADDR_HOLD, phases[p].hold);
         hold_cfg = phases[p].hold;
         csr_write(ADDR_LIMIT, 32'(phases[p].limit));
         limit_cfg = phases[p].limit;
         csr_read_check("hold_ticks", ADDR_HOLD, phases[p].hold);
         csr_read_check("entry_limit", ADDR_LIMIT, 32'(phases[p].limit));
         idle_pct = phases[p].idle;
         repeat (phases[p].items)
            send_random_word(phases[p].step_max);
      end

      // window counter: a burst of opens, then a burst of closes, then one consume
      idle_pct = 0;
      repeat (TAIL_WORDS)
         send_word(ACT_OPEN, cur_tick, '0, '0, 1'b0, '0);
      repeat (TAIL_WORDS)
         send_word(ACT_CLOSE, cur_tick, '0, '0, 1'b0, '0);
      send_word(ACT_CONSUME, cur_tick, '0, '1, 1'b0, '0);

      drain_results();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
